@@ hw/rtl/pnesc_pkg.sv @@
// shared types, constants and helpers of the path name escape encoder
package pnesc_pkg;

  localparam int BURST_MAX = 5;
  localparam int BURST_W   = 8 * BURST_MAX;
  localparam int BCNT_W    = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam int CAP_W = 16;
  localparam logic [CAP_W-1:0] CAP_RESET     = 16'd1024;
  localparam logic [CAP_W-1:0] BUDGET_MARGIN = 16'd4;

  localparam logic REG_SPLIT = 1'b0;
  localparam logic REG_CAP   = 1'b1;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ELEM  = 2'd1;
  localparam logic [1:0] PH_SLASH = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWA  = 8'h61;

  typedef struct packed {
    logic [BURST_W-1:0] data;
    logic [BCNT_W-1:0]  cnt;
    logic               term;
  } burst_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = CH_LOWA + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pnesc_front.sv @@
// front end: takes items, tracks phase and budget, builds output bursts
module pnesc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic [7:0]                       name_byte,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [pnesc_pkg::CAP_W-1:0]      cfg_data,
  input  logic                             q_full,
  output logic                             push,
  output pnesc_pkg::burst_t                push_data
);
  import pnesc_pkg::*;

  logic             split;
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] budget;
  logic [CAP_W-1:0] budget_next;
  logic [1:0]       phase;
  logic [1:0]       phase_next;

  logic             in_accept;
  logic             g0, g1, g2;
  logic             is_slash;
  logic             esc;
  logic [23:0]      ch_vec;
  logic [BCNT_W-1:0] cl;
  logic [15:0]      pre_vec;
  logic [1:0]       pl;
  logic             do_char;
  logic [BURST_W-1:0] ch_shift;
  logic [BCNT_W-1:0] n;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  assign g0 = budget > BUDGET_MARGIN;
  assign g1 = budget > BUDGET_MARGIN + 16'd1;
  assign g2 = budget > BUDGET_MARGIN + 16'd2;
  assign is_slash = name_byte == CH_SLASH;

  always_comb begin
    esc = (name_byte == CH_PCT) || (name_byte == CH_LF) || (name_byte == CH_CR) ||
          (!split && is_slash);
    if (esc) begin
      ch_vec = {hex_digit(name_byte[3:0]), hex_digit(name_byte[7:4]), CH_PCT};
      cl     = 3'd3;
    end else begin
      ch_vec = {16'd0, name_byte};
      cl     = 3'd1;
    end
  end

  always_comb begin
    pre_vec    = 16'd0;
    pl         = 2'd0;
    do_char    = 1'b0;
    phase_next = phase;
    if (split) begin
      unique case (phase)
        PH_START: begin
          if (!g0) begin
            phase_next = PH_STOP;
          end else if (is_slash) begin
            phase_next = PH_SLASH;
          end else begin
            pre_vec    = {8'd0, CH_F};
            pl         = 2'd1;
            do_char    = g1;
            phase_next = PH_ELEM;
          end
        end
        PH_ELEM: begin
          if (is_slash) begin
            phase_next = PH_SLASH;
          end else begin
            do_char = g0;
          end
        end
        PH_SLASH: begin
          if (!is_slash) begin
            pre_vec    = {CH_F, CH_SLASH};
            pl         = g1 ? 2'd2 : 2'd1;
            do_char    = g2;
            phase_next = g1 ? PH_ELEM : PH_STOP;
          end
        end
        PH_STOP: begin
        end
        default: begin
        end
      endcase
    end else begin
      unique case (phase)
        PH_START: begin
          if (g0) begin
            pre_vec    = {8'd0, CH_F};
            pl         = 2'd1;
            do_char    = g1;
            phase_next = PH_ELEM;
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_ELEM, PH_SLASH: begin
          phase_next = PH_ELEM;
          do_char    = g0;
        end
        PH_STOP: begin
        end
        default: begin
        end
      endcase
    end
    if (kind) begin
      phase_next = PH_START;
    end
  end

  always_comb begin
    case (pl)
      2'd1:    ch_shift = {8'd0, ch_vec, 8'd0};
      2'd2:    ch_shift = {ch_vec, 16'd0};
      default: ch_shift = {16'd0, ch_vec};
    endcase
  end

  always_comb begin
    n = {1'b0, pl} + (do_char ? cl : 3'd0);
    if (kind) begin
      push_data.data = '0;
      push_data.cnt  = 3'd1;
      push_data.term = 1'b1;
      budget_next    = cap;
    end else begin
      push_data.data = {24'd0, pre_vec} | (do_char ? ch_shift : '0);
      push_data.cnt  = n;
      push_data.term = 1'b0;
      budget_next    = (budget >= {13'd0, n}) ? budget - {13'd0, n} : '0;
    end
  end

  assign push = in_accept && (kind || (n != 3'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      split  <= 1'b1;
      cap    <= CAP_RESET;
      budget <= CAP_RESET;
      phase  <= PH_START;
    end else begin
      if (in_accept) begin
        budget <= budget_next;
        phase  <= phase_next;
      end
      if (cfg_write) begin
        if (cfg_index == REG_SPLIT) begin
          split <= cfg_data[0];
        end else begin
          cap <= cfg_data;
          if (phase == PH_START) begin
            budget <= cfg_data;
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_stop_silent: assert property (@(posedge clk) disable iff (rst)
    in_accept && (phase == PH_STOP) && !kind |-> !push)
    else $error("byte produced output after output stopped");
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    in_accept && kind |=> phase == PH_START)
    else $error("end of name did not return to start");
`endif

endmodule

@@ hw/rtl/pnesc_queue.sv @@
// short burst queue between front and back ends
module pnesc_queue #(
  parameter int DEPTH = pnesc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pnesc_pkg::burst_t  push_data,
  input  logic               pop,
  output pnesc_pkg::burst_t  head,
  output logic               full,
  output logic               empty
);
  import pnesc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  burst_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

@@ hw/rtl/pnesc_back.sv @@
// back end: walks each burst and drives one byte per transaction
module pnesc_back (
  input  logic               clk,
  input  logic               rst,
  input  pnesc_pkg::burst_t  head,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               is_terminator
);
  import pnesc_pkg::*;

  logic [BCNT_W-1:0] idx;
  logic              load;
  logic              last;

  assign load = !q_empty && (!out_valid || !out_stall);
  assign last = idx == head.cnt - 3'd1;
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? '0 : idx + 3'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= head.data[{idx, 3'b000} +: 8];
      is_terminator <= head.term;
    end
  end

`ifndef SYNTH
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_terminator |-> out_byte == 8'd0)
    else $error("terminator carries a nonzero byte");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx < head.cnt)
    else $error("burst index past burst length");
`endif

endmodule

@@ hw/rtl/path_name_escape_encoder_top.sv @@
// top level of the path name escape encoder
//
//  channel  direction  handshake                fields
//  in       input      in_valid / in_stall      kind, name_byte
//  out      output     out_valid / out_stall    out_byte, is_terminator
//  cfg      input      cfg_write                cfg_index, cfg_data
//
// one item accepted per cycle while the burst queue has room
// each item yields 0 to 5 bytes; the back end sends one byte per cycle while out_stall is low
// front and back are parted by a QUEUE_DEPTH entry burst queue
// output stall backs up the queue, then stalls the input
// reset is synchronous; registers return to split mode, capacity 1024
module path_name_escape_encoder_top #(
  parameter int QUEUE_DEPTH = pnesc_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [7:0]                   name_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         is_terminator,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [pnesc_pkg::CAP_W-1:0]  cfg_data
);
  import pnesc_pkg::*;

  logic   push;
  burst_t push_data;
  logic   pop;
  burst_t head;
  logic   q_full;
  logic   q_empty;

  pnesc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .name_byte (name_byte),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pnesc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pnesc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .is_terminator (is_terminator)
  );

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the path name escape encoder
`timescale 1ns / 100ps

module testbench;
  import pnesc_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam int   DRAIN_CYCLES = 4 * QUEUE_DEPTH + 8;
  localparam int   IDLE_PCT = 19;

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } out_txn_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = KIND_BYTE;
  logic [7:0]           name_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 is_terminator;
  logic                 cfg_write = 1'b0;
  logic                 cfg_index = REG_SPLIT;
  logic [CAP_W-1:0]     cfg_data = '0;

  // mirror of the encoder state
  logic                 split_mode = 1'b1;
  logic [CAP_W-1:0]     capacity = CAP_RESET;
  logic [CAP_W-1:0]     budget = CAP_RESET;
  logic [1:0]           phase = PH_START;

  out_txn_t             pending_bytes[$];
  bit                   quiet = 1'b0;
  int                   errors = 0;
  int                   items_sent = 0;
  int                   names_sent = 0;
  int                   results_seen = 0;
  int                   settings_used = 0;

  path_name_escape_encoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .name_byte     (name_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .is_terminator (is_terminator),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return CH_ZERO + {4'd0, v};
    end
    return CH_LOWA + {4'd0, v} - 8'd10;
  endfunction

  function automatic void expect_byte(input logic [7:0] b, input logic t);
    pending_bytes.push_back('{ch: b, term: t});
  endfunction

  function automatic void spend(input logic [CAP_W-1:0] k);
    budget = (budget >= k) ? budget - k : '0;
  endfunction

  function automatic void escape_char(input logic [7:0] c, input logic esc_slash);
    if (c == CH_PCT || c == CH_LF || c == CH_CR || (esc_slash && c == CH_SLASH)) begin
      expect_byte(CH_PCT, 1'b0);
      expect_byte(hex_char(c[7:4]), 1'b0);
      expect_byte(hex_char(c[3:0]), 1'b0);
      spend(16'd3);
    end else begin
      expect_byte(c, 1'b0);
      spend(16'd1);
    end
  endfunction

  function automatic void open_element(input logic [7:0] c, input logic esc_slash);
    expect_byte(CH_F, 1'b0);
    spend(16'd1);
    if (budget > BUDGET_MARGIN) begin
      escape_char(c, esc_slash);
    end
    phase = PH_ELEM;
  endfunction

  function automatic void encode_item(input logic k, input logic [7:0] c);
    if (k == KIND_END) begin
      expect_byte(8'h00, 1'b1);
      budget = capacity;
      phase = PH_START;
      return;
    end
    if (split_mode) begin
      case (phase)
        PH_START: begin
          if (budget <= BUDGET_MARGIN) phase = PH_STOP;
          else if (c == CH_SLASH) phase = PH_SLASH;
          else open_element(c, 1'b0);
        end
        PH_ELEM: begin
          if (c == CH_SLASH) phase = PH_SLASH;
          else if (budget > BUDGET_MARGIN) escape_char(c, 1'b0);
        end
        PH_SLASH: begin
          if (c != CH_SLASH) begin
            expect_byte(CH_SLASH, 1'b0);
            spend(16'd1);
            if (budget > BUDGET_MARGIN) open_element(c, 1'b0);
            else phase = PH_STOP;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase)
        PH_START: begin
          if (budget > BUDGET_MARGIN) open_element(c, 1'b1);
          else phase = PH_STOP;
        end
        PH_ELEM, PH_SLASH: begin
          phase = PH_ELEM;
          if (budget > BUDGET_MARGIN) escape_char(c, 1'b1);
        end
        default: ;
      endcase
    end
  endfunction

  // input transactions feed the mirror, output transactions are checked
  always @(posedge clk) begin : monitor
    out_txn_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        encode_item(kind, name_byte);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_bytes.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected output byte %02h term %0b", out_byte, is_terminator);
          end
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte !== want.ch || is_terminator !== want.term) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: byte %02h term %0b, expected byte %02h term %0b",
                       out_byte, is_terminator, want.ch, want.term);
            end
          end
        end
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_item(input logic k, input logic [7:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    name_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_name(input logic [7:0] chars[$]);
    foreach (chars[i]) send_item(KIND_BYTE, chars[i]);
    send_item(KIND_END, 8'($urandom_range(255)));
    names_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CAP_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_SPLIT) begin
      split_mode = val[0];
    end else begin
      capacity = val;
      if (phase == PH_START) budget = capacity;
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input bit noise);
    int r;
    r = $urandom_range(99);
    if (noise || r >= 45) return 8'($urandom_range(255));
    if (r < 25) return CH_SLASH;
    if (r < 33) return CH_PCT;
    if (r < 39) return CH_LF;
    return CH_CR;
  endfunction

  task automatic test_escapes_split();
    logic [7:0] no_chars[$];
    send_name(no_chars);
    send_name('{CH_SLASH, 8'h00, CH_PCT, CH_SLASH, CH_SLASH, CH_LF, CH_CR, 8'hff,
                CH_SLASH, CH_SLASH});
  endtask

  task automatic test_single_element();
    wait_idle();
    write_reg(REG_SPLIT, 16'd0);
    send_name('{CH_SLASH});
  endtask

  task automatic test_budget_edges();
    wait_idle();
    write_reg(REG_CAP, 16'd3);
    send_name('{8'h78});
    wait_idle();
    write_reg(REG_SPLIT, 16'd1);
    write_reg(REG_CAP, 16'd5);
    send_name('{8'h61, 8'h62, CH_SLASH, 8'h63});
  endtask

  task automatic test_midname_registers();
    wait_idle();
    write_reg(REG_CAP, 16'd1024);
    send_item(KIND_BYTE, 8'h61);
    send_item(KIND_BYTE, CH_SLASH);
    wait_idle();
    // pending slash dropped, capacity deferred to the next name
    write_reg(REG_SPLIT, 16'd0);
    write_reg(REG_CAP, 16'd6);
    send_name('{8'h62});
    send_name('{8'h7a, 8'h79});
  endtask

  task automatic send_random_name();
    int len;
    bit noise;
    len = $urandom_range(10);
    noise = ($urandom_range(99) < 20);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) < 6) begin
        wait_idle();
        if ($urandom_range(1)) begin
          write_reg(REG_SPLIT, {15'($urandom_range(32767)), ~split_mode});
        end else begin
          write_reg(REG_CAP, 16'($urandom_range(40, 5)));
        end
      end
      send_item(KIND_BYTE, pick_byte(noise));
    end
    send_item(KIND_END, 8'($urandom_range(255)));
    names_sent++;
  endtask

  task automatic test_random_names();
    int target;
    logic [CAP_W-1:0] cap;
    for (int p = 0; p < 10; p++) begin
      wait_idle();
      quiet = (p == 0);
      case (p)
        0: cap = 16'd1024;
        1: cap = 16'hffff;
        2: cap = 16'd5;
        3: cap = 16'd6;
        4: cap = 16'd9;
        5: cap = 16'd12;
        6: cap = 16'd4;
        7: cap = 16'd0;
        default: cap = 16'($urandom_range(40, 5));
      endcase
      write_reg(REG_SPLIT, {15'd0, ~p[0]});
      write_reg(REG_CAP, cap);
      settings_used++;
      target = items_sent + ((p == 6 || p == 7) ? 8 : 12);
      while (items_sent < target) send_random_name();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_escapes_split();
    test_single_element();
    test_budget_edges();
    test_midname_registers();
    test_random_names();
    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && pending_bytes.size() != 0; i++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      errors += pending_bytes.size();
      $display("%0d expected output bytes never arrived", pending_bytes.size());
    end
    $display("sent %0d names in %0d input transactions, checked %0d output transactions",
             names_sent, items_sent, results_seen);
    $display("random part ran under %0d register settings, %0d mismatches",
             settings_used, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ path_name_escape_encoder_top.f @@
hw/rtl/pnesc_pkg.sv
hw/rtl/pnesc_front.sv
hw/rtl/pnesc_queue.sv
hw/rtl/pnesc_back.sv
hw/rtl/path_name_escape_encoder_top.sv
tb/testbench.sv
